// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks clocked by clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// label: a condition that must hold at every edge
`define GTP_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");
// label: antecedent implies consequent in the same cycle
`define GTP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// label: antecedent implies consequent in the next cycle
`define GTP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GTP_ASSERT(lbl, cond)
`define GTP_ASSERT_IMP(lbl, ante, cons)
`define GTP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: sv/gtp_pkg.sv
// ----------------------------------------------------------------------------
// gtp_pkg
// Types, codes and constants shared by the go-to-pose sequencer modules.
// ----------------------------------------------------------------------------
package gtp_pkg;

  localparam int unsigned START_MOVE_TICKS_DEF       = 50;
  localparam longint unsigned APPROACH_TIMEOUT_DEF   = 64'd24000;
  localparam int unsigned ATAN_ITERATIONS_DEF        = 16;

  localparam int unsigned ATAN_IDX_W = 5;
  localparam int unsigned CORDIC_W   = 36;

  localparam logic [18:0] CMD_SAT        = 19'd262140;
  localparam logic [31:0] EXTRA_APPROACH = 32'd98304;
  localparam logic [31:0] QUARTER_TURN   = 32'h4000_0000;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  localparam logic [1:0] STAT_RUN  = 2'd0;
  localparam logic [1:0] STAT_OK   = 2'd1;
  localparam logic [1:0] STAT_FAIL = 2'd2;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_INIT   = 3'd1;
  localparam logic [2:0] ST_ROT    = 3'd2;
  localparam logic [2:0] ST_MSTART = 3'd3;
  localparam logic [2:0] ST_CRUISE = 3'd4;
  localparam logic [2:0] ST_MEND   = 3'd5;

  localparam logic [2:0] CFG_W_MAX   = 3'd0;
  localparam logic [2:0] CFG_W_MIN   = 3'd1;
  localparam logic [2:0] CFG_W_GAIN  = 3'd2;
  localparam logic [2:0] CFG_V_MAX   = 3'd3;
  localparam logic [2:0] CFG_V_MIN   = 3'd4;
  localparam logic [2:0] CFG_D_FINAL = 3'd5;
  localparam logic [2:0] CFG_EPS_YAW = 3'd6;
  localparam logic [2:0] CFG_EPS_POS = 3'd7;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] cur_x;
    logic signed [31:0] cur_y;
    logic signed [31:0] cur_z;
    logic signed [15:0] cur_heading;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [31:0] goal_z;
  } in_t;

  typedef struct packed {
    logic signed [18:0] angular_cmd;
    logic [15:0]        linear_cmd;
    logic [1:0]         status;
    logic [2:0]         stage_now;
  } out_t;

  typedef struct packed {
    logic [15:0] w_max;
    logic [15:0] w_min;
    logic [15:0] w_gain;
    logic [15:0] v_max;
    logic [15:0] v_min;
    logic [30:0] d_final;
    logic [14:0] eps_yaw;
    logic [30:0] eps_pos;
  } cfg_t;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_DX, MUL_DY, MUL_DZ, MUL_FIN, MUL_EPS, MUL_FAR,
    MUL_WW, MUL_EW, MUL_EWW, MUL_EN
  } mul_op_e;

  typedef struct packed {
    logic                  load;
    logic                  cordic_step;
    logic [ATAN_IDX_W-1:0] iter;
    logic                  head;
    mul_op_e               mul_op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0]         op;
    logic               lt_fin;
    logic               lt_eps;
    logic               gt_far;
    logic               e_pos;
    logic               e_neg;
    logic               e_lt_2eps;
    logic               e_lt_eps;
    logic signed [18:0] ang_rot;
    logic signed [18:0] ang_ms;
    logic signed [18:0] ang_cr;
    logic signed [18:0] ang_me;
  } dp_status_t;

  // atan(2^-i), full turn = 2^32
  function automatic logic [31:0] atan_at(input logic [ATAN_IDX_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

// File: sv/go_to_pose_motion_sequencer.sv
// ----------------------------------------------------------------------------
// go_to_pose_motion_sequencer
// Go-to-goal stage sequencer for a differential-drive robot.
// ----------------------------------------------------------------------------
// Each request runs the iterative CORDIC bearing loop, a heading step,
// three scaling products on the shared multiplier, a wait state and the final
// decision; no new request is taken until it is decided, and a waiting result
// holds the final decision.
// Reset: asynchronous, active low; stage idle, counters zero, configuration
// registers at their defaults.
module go_to_pose_motion_sequencer import gtp_pkg::*; #(
  parameter int unsigned     START_MOVE_TICKS       = START_MOVE_TICKS_DEF,
  parameter longint unsigned APPROACH_TIMEOUT_TICKS = APPROACH_TIMEOUT_DEF,
  parameter int unsigned     ATAN_ITERATIONS        = ATAN_ITERATIONS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [30:0] cfg_wdata_i
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t st;

  gtp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  gtp_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .cfg_i     (cfg),
    .cmd_i     (cmd),
    .status_o  (st)
  );

  gtp_ctrl #(
    .START_MOVE_TICKS       (START_MOVE_TICKS),
    .APPROACH_TIMEOUT_TICKS (APPROACH_TIMEOUT_TICKS),
    .ATAN_ITERATIONS        (ATAN_ITERATIONS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_i       (cfg),
    .cmd_o       (cmd),
    .st_i        (st)
  );

endmodule

// File: sv/gtp_cfg.sv
// ----------------------------------------------------------------------------
// gtp_cfg
// Configuration register file with write-only port and reset defaults.
// ----------------------------------------------------------------------------
module gtp_cfg import gtp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [30:0] cfg_wdata_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.w_max   <= 16'd256;
      cfg_q.w_min   <= 16'd26;
      cfg_q.w_gain  <= 16'd256;
      cfg_q.v_max   <= 16'd128;
      cfg_q.v_min   <= 16'd26;
      cfg_q.d_final <= 31'd65536;
      cfg_q.eps_yaw <= 15'd182;
      cfg_q.eps_pos <= 31'd6554;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_W_MAX:   cfg_q.w_max   <= cfg_wdata_i[15:0];
        CFG_W_MIN:   cfg_q.w_min   <= cfg_wdata_i[15:0];
        CFG_W_GAIN:  cfg_q.w_gain  <= cfg_wdata_i[15:0];
        CFG_V_MAX:   cfg_q.v_max   <= cfg_wdata_i[15:0];
        CFG_V_MIN:   cfg_q.v_min   <= cfg_wdata_i[15:0];
        CFG_D_FINAL: cfg_q.d_final <= cfg_wdata_i;
        CFG_EPS_YAW: cfg_q.eps_yaw <= cfg_wdata_i[14:0];
        CFG_EPS_POS: cfg_q.eps_pos <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/gtp_dp.sv
// ----------------------------------------------------------------------------
// gtp_dp
// Datapath: offset, iterative CORDIC bearing, shared 32x32 multiplier for
// squared distances and command scaling, and the compare flags.
// ----------------------------------------------------------------------------
module gtp_dp import gtp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_t        in_data_i,
  input  cfg_t       cfg_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o
);

  logic [1:0]                  op_q;
  logic signed [15:0]          head_q;
  logic signed [32:0]          dx_q, dy_q, dz_q;
  logic                        zero_q;
  logic signed [CORDIC_W-1:0]  x_q, y_q;
  logic [31:0]                 z_q;
  logic signed [15:0]          e_q;
  logic [63:0]                 p_q;
  mul_op_e                     tag_q;
  logic [65:0]                 acc_q;
  logic [63:0]                 fin2_q, eps2_q, far2_q;
  logic [31:0]                 ww_q, pew_q, pen_q;
  logic [47:0]                 peww_q;

  // offsets and pre-rotation into the right half plane
  logic signed [32:0]         dx_d, dy_d, dz_d;
  logic signed [CORDIC_W-1:0] x0, y0, dxe, dye;
  logic [31:0]                z0;

  always_comb begin
    dx_d = 33'(in_data_i.goal_x) - 33'(in_data_i.cur_x);
    dy_d = 33'(in_data_i.goal_y) - 33'(in_data_i.cur_y);
    dz_d = 33'(in_data_i.goal_z) - 33'(in_data_i.cur_z);
    dxe  = CORDIC_W'(dx_d);
    dye  = CORDIC_W'(dy_d);
    x0   = dxe;
    y0   = dye;
    z0   = '0;
    if (dx_d < 0) begin
      if (dy_d >= 0) begin
        x0 = dye;
        y0 = -dxe;
        z0 = QUARTER_TURN;
      end else begin
        x0 = -dye;
        y0 = dxe;
        z0 = -QUARTER_TURN;
      end
    end
  end

  // heading error and its magnitude
  logic [15:0] bearing;
  logic [31:0] z_rnd;
  logic [16:0] abse;

  always_comb begin
    z_rnd   = z_q + 32'h8000;
    bearing = zero_q ? 16'd0 : z_rnd[31:16];
    abse    = e_q[15] ? 17'(-18'(e_q)) : {1'b0, e_q};
  end

  // magnitudes for squaring
  function automatic logic [31:0] mag32(input logic signed [32:0] v);
    logic signed [32:0] n;
    n = -v;
    return v[32] ? n[31:0] : v[31:0];
  endfunction

  logic [31:0] far_l;
  logic [31:0] mul_a, mul_b;

  always_comb begin
    far_l = 32'(cfg_i.d_final) + EXTRA_APPROACH;
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_op)
      MUL_DX:  begin mul_a = mag32(dx_q); mul_b = mag32(dx_q); end
      MUL_DY:  begin mul_a = mag32(dy_q); mul_b = mag32(dy_q); end
      MUL_DZ:  begin mul_a = mag32(dz_q); mul_b = mag32(dz_q); end
      MUL_FIN: begin mul_a = 32'(cfg_i.d_final); mul_b = 32'(cfg_i.d_final); end
      MUL_EPS: begin mul_a = 32'(cfg_i.eps_pos); mul_b = 32'(cfg_i.eps_pos); end
      MUL_FAR: begin mul_a = far_l; mul_b = far_l; end
      MUL_WW:  begin mul_a = 32'(cfg_i.w_max); mul_b = 32'(cfg_i.w_gain); end
      MUL_EW:  begin mul_a = 32'(abse); mul_b = 32'(cfg_i.w_max); end
      MUL_EWW: begin mul_a = 32'(abse); mul_b = ww_q; end
      MUL_EN:  begin mul_a = 32'(abse); mul_b = 32'(cfg_i.w_min); end
      default: ;
    endcase
  end

  // CORDIC step
  logic signed [CORDIC_W-1:0] xs, ys;
  assign xs = x_q >>> cmd_i.iter;
  assign ys = y_q >>> cmd_i.iter;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= MUL_NONE;
    end else begin
      tag_q <= cmd_i.mul_op;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= 64'(mul_a) * 64'(mul_b);
    if (cmd_i.load) begin
      op_q   <= in_data_i.opcode;
      head_q <= in_data_i.cur_heading;
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      dz_q   <= dz_d;
      zero_q <= (dx_d == 0) && (dy_d == 0);
      x_q    <= x0;
      y_q    <= y0;
      z_q    <= z0;
      acc_q  <= '0;
    end else begin
      if (cmd_i.cordic_step) begin
        if (y_q > 0) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + atan_at(cmd_i.iter);
        end else begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - atan_at(cmd_i.iter);
        end
      end
      case (tag_q)
        MUL_DX, MUL_DY, MUL_DZ: acc_q <= acc_q + 66'(p_q);
        default: ;
      endcase
    end
    if (cmd_i.head) begin
      e_q <= bearing - head_q;
    end
    case (tag_q)
      MUL_FIN: fin2_q <= p_q;
      MUL_EPS: eps2_q <= p_q;
      MUL_FAR: far2_q <= p_q;
      MUL_WW:  ww_q   <= p_q[31:0];
      MUL_EW:  pew_q  <= p_q[31:0];
      MUL_EWW: peww_q <= p_q[47:0];
      MUL_EN:  pen_q  <= p_q[31:0];
      default: ;
    endcase
  end

  function automatic logic [17:0] sat_mag(input logic [47:0] m);
    return (m > 48'(CMD_SAT)) ? CMD_SAT[17:0] : m[17:0];
  endfunction

  function automatic logic signed [18:0] signed_cmd(input logic [17:0] m,
                                                    input logic neg);
    return neg ? -19'(m) : 19'(m);
  endfunction

  logic [63:0] dsq;
  logic [17:0] m_rot, m_ms, m_cr, m_me;
  logic        e_neg, e_pos;

  always_comb begin
    dsq   = (|acc_q[65:64]) ? '1 : acc_q[63:0];
    e_neg = e_q[15];
    e_pos = !e_q[15] && (e_q != 0);
    m_rot = sat_mag(48'(pew_q >> 15));
    if ((e_pos || e_neg) && (m_rot < 18'(cfg_i.w_min))) begin
      m_rot = 18'(cfg_i.w_min);
    end
    m_ms = sat_mag(48'(peww_q >> 23));
    m_cr = sat_mag(48'(pew_q >> 13));
    m_me = sat_mag(48'(pen_q >> 15));

    status_o.op        = op_q;
    status_o.lt_fin    = dsq < fin2_q;
    status_o.lt_eps    = dsq < eps2_q;
    status_o.gt_far    = dsq > far2_q;
    status_o.e_pos     = e_pos;
    status_o.e_neg     = e_neg;
    status_o.e_lt_2eps = abse < {1'b0, cfg_i.eps_yaw, 1'b0};
    status_o.e_lt_eps  = abse < 17'(cfg_i.eps_yaw);
    status_o.ang_rot   = signed_cmd(m_rot, e_neg);
    status_o.ang_ms    = signed_cmd(m_ms, e_neg);
    status_o.ang_cr    = signed_cmd(m_cr, e_neg);
    status_o.ang_me    = signed_cmd(m_me, e_neg);
  end

endmodule

// File: sv/gtp_ctrl.sv
// ----------------------------------------------------------------------------
// gtp_ctrl
// Sequencer for the datapath and the motion stage machine with its counters
// and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gtp_ctrl import gtp_pkg::*; #(
  parameter int unsigned      START_MOVE_TICKS       = START_MOVE_TICKS_DEF,
  parameter longint unsigned  APPROACH_TIMEOUT_TICKS = APPROACH_TIMEOUT_DEF,
  parameter int unsigned      ATAN_ITERATIONS        = ATAN_ITERATIONS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_t       out_data_o,
  input  cfg_t       cfg_i,
  output dp_cmd_t    cmd_o,
  input  dp_status_t st_i
);

  localparam int unsigned CW = $clog2(ATAN_ITERATIONS);

  typedef enum logic [2:0] {
    S_IDLE, S_CORDIC, S_HEAD, S_SCALE, S_WAIT, S_DECIDE
  } seq_e;

  seq_e        state_q;
  logic [CW-1:0] cnt_q;
  logic [1:0]  sc_q;
  logic [2:0]  stage_q, stage_d;
  logic [15:0] slc_q, slc_d;
  logic [31:0] timer_q, timer_d;
  out_t        out_q, out_d;
  logic        out_valid_q;

  function automatic mul_op_e early_op(input logic [CW-1:0] i);
    mul_op_e m;
    case (ATAN_IDX_W'(i))
      5'd0: m = MUL_DX;
      5'd1: m = MUL_DY;
      5'd2: m = MUL_DZ;
      5'd3: m = MUL_FIN;
      5'd4: m = MUL_EPS;
      5'd5: m = MUL_FAR;
      5'd6: m = MUL_WW;
      default: m = MUL_NONE;
    endcase
    return m;
  endfunction

  logic in_acc;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.load        = in_acc;
    cmd_o.cordic_step = (state_q == S_CORDIC);
    cmd_o.iter        = ATAN_IDX_W'(cnt_q);
    cmd_o.head        = (state_q == S_HEAD);
    cmd_o.mul_op      = MUL_NONE;
    case (state_q)
      S_CORDIC: cmd_o.mul_op = early_op(cnt_q);
      S_SCALE: begin
        case (sc_q)
          2'd0:    cmd_o.mul_op = MUL_EW;
          2'd1:    cmd_o.mul_op = MUL_EWW;
          default: cmd_o.mul_op = MUL_EN;
        endcase
      end
      default: ;
    endcase
  end

  // stage machine
  logic [15:0] slc_inc;
  logic [31:0] timer_inc;

  always_comb begin
    stage_d  = stage_q;
    slc_d    = slc_q;
    timer_d  = timer_q;
    out_d.angular_cmd = '0;
    out_d.linear_cmd  = '0;
    out_d.status      = STAT_RUN;
    slc_inc   = (slc_q != 16'hFFFF) ? slc_q + 16'd1 : slc_q;
    timer_inc = (timer_q != 32'hFFFF_FFFF) ? timer_q + 32'd1 : timer_q;
    case (st_i.op)
      OP_START: begin
        stage_d      = ST_INIT;
        slc_d        = '0;
        out_d.status = STAT_OK;
      end
      OP_FINISH: begin
        stage_d      = ST_IDLE;
        out_d.status = STAT_OK;
      end
      OP_TICK: begin
        case (stage_q)
          ST_INIT: begin
            if (st_i.lt_fin) begin
              stage_d = ST_MEND;
              timer_d = '0;
            end else begin
              stage_d = ST_ROT;
            end
          end
          ST_ROT: begin
            out_d.angular_cmd = st_i.ang_rot;
            if (st_i.e_lt_2eps) begin
              stage_d = ST_MSTART;
              slc_d   = '0;
            end
          end
          ST_MSTART: begin
            out_d.angular_cmd = st_i.ang_ms;
            slc_d = slc_inc;
            if ((slc_inc > 16'(START_MOVE_TICKS)) || st_i.e_lt_eps) begin
              if (st_i.lt_fin) begin
                stage_d = ST_MEND;
                timer_d = '0;
              end else begin
                stage_d = ST_CRUISE;
              end
            end
          end
          ST_CRUISE: begin
            out_d.angular_cmd = st_i.ang_cr;
            out_d.linear_cmd  = cfg_i.v_max;
            if (st_i.lt_fin) begin
              stage_d = ST_MEND;
              timer_d = '0;
            end
          end
          ST_MEND: begin
            out_d.angular_cmd = st_i.ang_me;
            out_d.linear_cmd  = cfg_i.v_min;
            if (st_i.lt_eps) begin
              stage_d      = ST_IDLE;
              out_d.status = STAT_OK;
            end else if (st_i.gt_far) begin
              stage_d = ST_ROT;
            end else begin
              timer_d = timer_inc;
              if (timer_inc >= 32'(APPROACH_TIMEOUT_TICKS)) begin
                stage_d = ST_ROT;
              end
            end
          end
          default: out_d.status = STAT_FAIL;
        endcase
      end
      default: out_d.status = STAT_FAIL;
    endcase
    out_d.stage_now = stage_d;
  end

  logic decide_go;
  // hold the decision until the previous result has been taken
  assign decide_go = (state_q == S_DECIDE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      sc_q        <= '0;
      stage_q     <= ST_IDLE;
      slc_q       <= '0;
      timer_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (decide_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_CORDIC;
            cnt_q   <= '0;
          end
        end
        S_CORDIC: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(ATAN_ITERATIONS - 1)) begin
            state_q <= S_HEAD;
          end
        end
        S_HEAD: begin
          state_q <= S_SCALE;
          sc_q    <= '0;
        end
        S_SCALE: begin
          sc_q <= sc_q + 2'd1;
          if (sc_q == 2'd2) begin
            state_q <= S_WAIT;
          end
        end
        S_WAIT: state_q <= S_DECIDE;
        S_DECIDE: begin
          if (decide_go) begin
            stage_q <= stage_d;
            slc_q   <= slc_d;
            timer_q <= timer_d;
            out_q   <= out_d;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `GTP_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ready_o)
  `GTP_ASSERT(a_stage_legal, stage_q <= ST_MEND)
  `GTP_ASSERT_IMP(a_result_from_decide, $rose(out_valid_q), $past(state_q == S_DECIDE))

endmodule

// File: verif/go_to_pose_motion_sequencer_tb.sv
// ----------------------------------------------------------------------------
// go_to_pose_motion_sequencer_tb
// Drives start, tick, finish and unused opcodes through the sequencer under
// several register settings and random idling on both channels. A scoreboard
// class predicts every command and compares it field by field with the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module go_to_pose_motion_sequencer_tb import gtp_pkg::*; ();

  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam int          NUM_PHASES  = 4;
  localparam int          RAND_ITEMS  = 200;
  localparam int          TAIL_CYCLES = 40;
  localparam int          HOLD_CYCLES = 400;
  localparam longint      CYCLE_LIMIT = 1500000;
  localparam longint unsigned TIMEOUT_TICKS = 24000;

  // atan(2^-i), full turn = 2^32
  localparam longint ATAN_Q32 [16] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [30:0] cfg_wdata;

  int     tx_idle_pct;
  int     rx_idle_pct;
  logic   rx_hold;
  logic   hold_req;
  longint cycles = 0;

  // CORDIC bearing of (dx, dy) minus heading, wrapped to 16 bits
  function automatic int heading_error(longint dx, longint dy, logic signed [15:0] head);
    longint x, y, z, t, xs, ys;
    logic [31:0] zl;
    logic [15:0] bearing, u;
    logic signed [15:0] s;
    bearing = '0;
    if (dx != 0 || dy != 0) begin
      x = dx;
      y = dy;
      z = 0;
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; z = 64'sh40000000;
        end else begin
          t = x; x = -y; y = t; z = -64'sh40000000;
        end
      end
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x += ys; y -= xs; z += ATAN_Q32[i];
        end else begin
          x -= ys; y += xs; z -= ATAN_Q32[i];
        end
      end
      zl = z[31:0] + 32'h8000;
      bearing = zl[31:16];
    end
    u = bearing - head;
    s = u;
    return s;
  endfunction

  function automatic logic [63:0] sq_acc(logic [63:0] acc, longint d);
    longint unsigned a, s;
    a = (d < 0) ? -d : d;
    s = a * a;
    if (acc > 64'hFFFF_FFFF_FFFF_FFFF - s) return 64'hFFFF_FFFF_FFFF_FFFF;
    return acc + s;
  endfunction

  function automatic int scale_cmd(int e, longint unsigned mul, int sh);
    longint unsigned mag;
    mag = longint'((e < 0) ? -e : e) * mul;
    mag = mag >> sh;
    if (mag > 262140) mag = 262140;
    return (e < 0) ? -int'(mag) : int'(mag);
  endfunction

  class motion_cmd_scoreboard;
    cfg_t            regs;
    logic [2:0]      stage;
    int unsigned     start_cnt;
    longint unsigned approach_ticks;
    out_t            expected_cmds[$];
    int              errors;

    function new();
      regs = '{w_max: 16'd256, w_min: 16'd26, w_gain: 16'd256, v_max: 16'd128,
               v_min: 16'd26, d_final: 31'd65536, eps_yaw: 15'd182, eps_pos: 31'd6554};
      stage = ST_IDLE;
      start_cnt = 0;
      approach_ticks = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [30:0] val);
      case (idx)
        CFG_W_MAX:   regs.w_max = val[15:0];
        CFG_W_MIN:   regs.w_min = val[15:0];
        CFG_W_GAIN:  regs.w_gain = val[15:0];
        CFG_V_MAX:   regs.v_max = val[15:0];
        CFG_V_MIN:   regs.v_min = val[15:0];
        CFG_D_FINAL: regs.d_final = val;
        CFG_EPS_YAW: regs.eps_yaw = val[14:0];
        CFG_EPS_POS: regs.eps_pos = val;
        default: ;
      endcase
    endfunction

    function void enter_approach();
      stage = ST_MEND;
      approach_ticks = 0;
    endfunction

    function void note_request(in_t it);
      longint dx, dy, dz;
      logic [63:0] dsq, fin2, eps2, far2, farl;
      int e, abse, ang;
      logic [15:0] lin;
      logic [1:0] stat;
      out_t r;
      dx = longint'(it.goal_x) - longint'(it.cur_x);
      dy = longint'(it.goal_y) - longint'(it.cur_y);
      dz = longint'(it.goal_z) - longint'(it.cur_z);
      dsq = sq_acc(sq_acc(sq_acc(64'd0, dx), dy), dz);
      e = heading_error(dx, dy, it.cur_heading);
      abse = (e < 0) ? -e : e;
      fin2 = 64'(regs.d_final) * 64'(regs.d_final);
      eps2 = 64'(regs.eps_pos) * 64'(regs.eps_pos);
      farl = 64'(regs.d_final) + 64'd98304;
      far2 = farl * farl;
      ang = 0;
      lin = '0;
      stat = STAT_RUN;
      if (it.opcode == OP_START) begin
        stage = ST_INIT;
        start_cnt = 0;
        stat = STAT_OK;
      end else if (it.opcode == OP_FINISH) begin
        stage = ST_IDLE;
        stat = STAT_OK;
      end else if (it.opcode == OP_UNUSED) begin
        stat = STAT_FAIL;
      end else begin
        case (stage)
          ST_INIT: begin
            if (dsq < fin2) enter_approach();
            else stage = ST_ROT;
          end
          ST_ROT: begin
            ang = scale_cmd(e, regs.w_max, 15);
            if (e > 0 && ang < int'(regs.w_min)) ang = int'(regs.w_min);
            if (e < 0 && ang > -int'(regs.w_min)) ang = -int'(regs.w_min);
            if (abse < 2 * int'(regs.eps_yaw)) begin
              stage = ST_MSTART;
              start_cnt = 0;
            end
          end
          ST_MSTART: begin
            ang = scale_cmd(e, 64'(regs.w_max) * 64'(regs.w_gain), 23);
            if (start_cnt < 65535) start_cnt++;
            if (start_cnt > START_MOVE_TICKS_DEF || abse < int'(regs.eps_yaw)) begin
              if (dsq < fin2) enter_approach();
              else stage = ST_CRUISE;
            end
          end
          ST_CRUISE: begin
            ang = scale_cmd(e, regs.w_max, 13);
            lin = regs.v_max;
            if (dsq < fin2) enter_approach();
          end
          ST_MEND: begin
            ang = scale_cmd(e, regs.w_min, 15);
            lin = regs.v_min;
            if (dsq < eps2) begin
              stage = ST_IDLE;
              stat = STAT_OK;
            end else if (dsq > far2) begin
              stage = ST_ROT;
            end else begin
              if (approach_ticks < 64'hFFFF_FFFF) approach_ticks++;
              if (approach_ticks >= TIMEOUT_TICKS) stage = ST_ROT;
            end
          end
          default: stat = STAT_FAIL;
        endcase
      end
      r.angular_cmd = 19'(ang);
      r.linear_cmd = lin;
      r.status = stat;
      r.stage_now = stage;
      expected_cmds.push_back(r);
    endfunction

    function void check_command(out_t got);
      out_t exp_cmd;
      if (expected_cmds.size() == 0) begin
        $error("unexpected command transaction: %p", got);
        errors++;
        return;
      end
      exp_cmd = expected_cmds.pop_front();
      if (got.angular_cmd !== exp_cmd.angular_cmd) begin
        $error("angular_cmd: expected %0d, actual %0d", exp_cmd.angular_cmd, got.angular_cmd);
        errors++;
      end
      if (got.linear_cmd !== exp_cmd.linear_cmd) begin
        $error("linear_cmd: expected %0d, actual %0d", exp_cmd.linear_cmd, got.linear_cmd);
        errors++;
      end
      if (got.status !== exp_cmd.status) begin
        $error("status: expected %0d, actual %0d", exp_cmd.status, got.status);
        errors++;
      end
      if (got.stage_now !== exp_cmd.stage_now) begin
        $error("stage_now: expected %0d, actual %0d", exp_cmd.stage_now, got.stage_now);
        errors++;
      end
    endfunction
  endclass

  motion_cmd_scoreboard sb;

  go_to_pose_motion_sequencer i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_command(out_data);
  end

  always @(negedge clk) begin
    out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  // hold off the receiver for a long stretch on request
  initial begin
    forever begin
      wait (hold_req);
      rx_hold = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      rx_hold = 1'b0;
      hold_req = 1'b0;
    end
  end

  function automatic in_t mk(logic [1:0] op, logic signed [31:0] cx, logic signed [31:0] cy,
                             logic signed [31:0] cz, logic signed [15:0] h,
                             logic signed [31:0] gx, logic signed [31:0] gy,
                             logic signed [31:0] gz);
    in_t it;
    it.opcode = op;
    it.cur_x = cx; it.cur_y = cy; it.cur_z = cz;
    it.cur_heading = h;
    it.goal_x = gx; it.goal_y = gy; it.goal_z = gz;
    return it;
  endfunction

  function automatic logic signed [15:0] bearing_to(logic signed [31:0] cx,
                                                    logic signed [31:0] cy,
                                                    logic signed [31:0] gx,
                                                    logic signed [31:0] gy);
    return 16'(heading_error(longint'(gx) - longint'(cx), longint'(gy) - longint'(cy), 16'sd0));
  endfunction

  function automatic logic signed [31:0] offset_of(int kind);
    case (kind)
      0: return 32'sd0;
      1: return $signed(32'($urandom_range(0, 6000))) - 32'sd3000;
      2: return $signed(32'($urandom_range(0, 80000))) - 32'sd40000;
      3: return $signed(32'($urandom_range(0, 240000))) - 32'sd120000;
      default: return $signed(32'($urandom_range(0, 33554432))) - 32'sd16777216;
    endcase
  endfunction

  function automatic in_t rand_item();
    in_t it;
    int r, kind;
    r = $urandom_range(99);
    if (r < 6) it.opcode = OP_START;
    else if (r < 10) it.opcode = OP_FINISH;
    else if (r < 12) it.opcode = OP_UNUSED;
    else it.opcode = OP_TICK;
    if ($urandom_range(3) == 0) begin
      it.cur_x = $urandom; it.cur_y = $urandom; it.cur_z = $urandom;
    end else begin
      it.cur_x = $signed(32'($urandom_range(0, 2097152))) - 32'sd1048576;
      it.cur_y = $signed(32'($urandom_range(0, 2097152))) - 32'sd1048576;
      it.cur_z = $signed(32'($urandom_range(0, 2097152))) - 32'sd1048576;
    end
    kind = $urandom_range(0, 5);
    if (kind == 5) begin
      it.goal_x = $urandom; it.goal_y = $urandom; it.goal_z = $urandom;
    end else begin
      it.goal_x = it.cur_x + offset_of(kind);
      it.goal_y = it.cur_y + offset_of(kind);
      it.goal_z = it.cur_z + offset_of($urandom_range(0, 2));
    end
    // mostly point at the goal so that rotate and move start can be left
    if ($urandom_range(9) < 6)
      it.cur_heading = bearing_to(it.cur_x, it.cur_y, it.goal_x, it.goal_y)
                       + $signed(16'($urandom_range(0, 1200))) - 16'sd600;
    else
      it.cur_heading = $urandom;
    return it;
  endfunction

  task automatic send_request(in_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_request(it);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_cmds.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [30:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic load_regs(int sel);
    case (sel)
      0: begin
        write_reg(CFG_W_MAX, 31'd256);    write_reg(CFG_W_MIN, 31'd26);
        write_reg(CFG_W_GAIN, 31'd256);   write_reg(CFG_V_MAX, 31'd128);
        write_reg(CFG_V_MIN, 31'd26);     write_reg(CFG_D_FINAL, 31'd65536);
        write_reg(CFG_EPS_YAW, 31'd182);  write_reg(CFG_EPS_POS, 31'd6554);
      end
      1: begin
        write_reg(CFG_W_MAX, 31'hFFFF);     write_reg(CFG_W_MIN, 31'hFFFF);
        write_reg(CFG_W_GAIN, 31'hFFFF);    write_reg(CFG_V_MAX, 31'hFFFF);
        write_reg(CFG_V_MIN, 31'hFFFF);     write_reg(CFG_D_FINAL, 31'h7FFFFFFF);
        write_reg(CFG_EPS_YAW, 31'h7FFF);   write_reg(CFG_EPS_POS, 31'h7FFFFFFF);
      end
      2: begin
        write_reg(CFG_W_MAX, 31'd0);   write_reg(CFG_W_MIN, 31'd0);
        write_reg(CFG_W_GAIN, 31'd0);  write_reg(CFG_V_MAX, 31'd0);
        write_reg(CFG_V_MIN, 31'd0);   write_reg(CFG_D_FINAL, 31'd0);
        write_reg(CFG_EPS_YAW, 31'd0); write_reg(CFG_EPS_POS, 31'd0);
      end
      default: begin
        write_reg(CFG_W_MAX, 31'($urandom_range(1, 65535)));
        write_reg(CFG_W_MIN, 31'($urandom_range(0, 2000)));
        write_reg(CFG_W_GAIN, 31'($urandom_range(0, 65535)));
        write_reg(CFG_V_MAX, 31'($urandom_range(0, 65535)));
        write_reg(CFG_V_MIN, 31'($urandom_range(0, 65535)));
        write_reg(CFG_D_FINAL, 31'($urandom_range(20000, 200000)));
        write_reg(CFG_EPS_YAW, 31'($urandom_range(50, 3000)));
        write_reg(CFG_EPS_POS, 31'($urandom_range(1000, 30000)));
      end
    endcase
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    rx_hold = 1'b0;
    hold_req = 1'b0;
    tx_idle_pct = 9;
    rx_idle_pct = 71;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 2) begin
        tx_idle_pct = 71; rx_idle_pct = 9;
      end else if (ph == 3) begin
        tx_idle_pct = 0; rx_idle_pct = 0;
      end
      if (ph > 0) drain();
      load_regs(ph);

      if (ph == 0) begin
        // full walk: init, rotate, move start, cruise, move end, arrival
        send_request(mk(OP_START, 0, 0, 0, 0, 32'sd300000, 0, 0));
        send_request(mk(OP_TICK, 0, 0, 0, 16'sd8000, 32'sd300000, 0, 0));
        send_request(mk(OP_TICK, 0, 0, 0, 16'sd30, 32'sd300000, 0, 0));
        send_request(mk(OP_TICK, 0, 0, 0, 16'sd5, 32'sd300000, 0, 0));
        send_request(mk(OP_TICK, 0, 0, 0, -16'sd200, 32'sd300000, 0, 0));
        send_request(mk(OP_TICK, 0, 0, 0, 16'sd100, 32'sd40000, 0, 0));
        send_request(mk(OP_TICK, 0, 0, 0, -16'sd100, 32'sd20000, 32'sd3000, 0));
        send_request(mk(OP_TICK, 0, 0, 0, 0, 32'sd1000, 0, 32'sd500));
        send_request(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
        // init straight into move end, then fall back to rotate when far
        send_request(mk(OP_START, 0, 0, 0, 0, 0, 0, 0));
        send_request(mk(OP_TICK, 0, 0, 0, 0, 32'sd20000, 0, 0));
        send_request(mk(OP_TICK, 0, 0, 0, 0, 32'sd200000, 0, 0));
        // rotate clamp, then move start and cruise; half turn, zero offset
        send_request(mk(OP_TICK, 0, 0, 0, 16'sd40, 32'sd300000, 0, 0));
        send_request(mk(OP_TICK, 0, 0, 0, -16'sd40, 32'sd300000, 0, 0));
        send_request(mk(OP_TICK, 0, 0, 0, 16'h8000, 32'sd300000, 0, 0));
        send_request(mk(OP_TICK, 0, 0, 0, 0, -32'sd300000, 0, 0));
        send_request(mk(OP_TICK, 32'sd5, 32'sd7, 0, 16'sd1234, 32'sd5, 32'sd7, 32'sd90000));
        // extremes of every coordinate
        send_request(mk(OP_TICK, 32'h80000000, 32'h80000000, 32'h80000000, 16'h7FFF,
                        32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
        send_request(mk(OP_TICK, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'h8000,
                        32'h80000000, 32'h7FFFFFFF, 32'h80000000));
        send_request(mk(OP_FINISH, 32'hFFFFFFFF, 0, 0, 16'hFFFF, 0, 32'hFFFFFFFF, 0));
        send_request(mk(OP_TICK, 0, 0, 0, 0, 32'sd300000, 0, 0));
        send_request(mk(OP_UNUSED, 0, 0, 0, 0, 32'sd300000, 0, 0));
      end

      for (int n = 0; n < RAND_ITEMS; n++) begin
        if (ph == 3 && n == 60) hold_req = 1'b1;
        // let the pipe empty before going on
        if (ph == 3 && n == 140) begin
          in_valid <= 1'b0;
          while (sb.expected_cmds.size() != 0) @(negedge clk);
        end
        send_request(rand_item());
      end
    end

    in_valid <= 1'b0;
    while (sb.expected_cmds.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
